>>> design/dswrl_pkg.sv
// Package for the dual sliding-window rate limiter.
// Holds request/response word types, window spans and config indexes.
// No dependencies.
`timescale 1ns / 1ps

package dswrl_pkg;

    // Depth defaults for the two grant logs
    localparam int SECOND_DEPTH_DEF = 64;
    localparam int MINUTE_DEPTH_DEF = 1024;

    // Window spans, retry floor and retry ceiling, in ms
    localparam logic [31:0] SEC_SPAN_MS = 32'd1000;
    localparam logic [31:0] MIN_SPAN_MS = 32'd60000;
    localparam logic [15:0] MIN_WAIT_MS = 16'd20;
    localparam logic [15:0] MAX_WAIT_MS = 16'd60000;

    // Config port
    localparam int SEC_LIM_W = 7;
    localparam int MIN_LIM_W = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PER_SECOND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_MINUTE = 1'b1;

    // Request word
    typedef struct packed {
        logic [31:0] now_ms;
        logic        stop;
    } t_req;

    // Response word
    typedef struct packed {
        logic        granted;
        logic        stopped;
        logic [15:0] wait_ms;
    } t_rsp;

endpackage

>>> design/dual_sliding_window_rate_limiter.sv
// Dual sliding-window rate limiter over one-second and one-minute grant logs.
// An accepted word is pruned first (aged entries retire from both logs in parallel,
// one per cycle each), then its response goes into the output register, or is held
// while the slot is stalled; a stop word skips pruning. One word at a time: the input
// stalls until its response is loaded. Sync active-low reset clears limits, heads,
// counts and handshake state; the log RAMs are not cleared. Depends on dswrl_pkg.
`timescale 1ns / 1ps

module dual_sliding_window_rate_limiter #(
    parameter int SECOND_DEPTH = dswrl_pkg::SECOND_DEPTH_DEF,
    parameter int MINUTE_DEPTH = dswrl_pkg::MINUTE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [dswrl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dswrl_pkg::CFG_W-1:0]    i_cfg_wdata,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dswrl_pkg::t_req                i_in_data,
    // response channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dswrl_pkg::t_rsp                o_out_data
);
    import dswrl_pkg::*;

    localparam int SIW = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
    localparam int SCW = $clog2(SECOND_DEPTH + 1);
    localparam int MIW = (MINUTE_DEPTH > 1) ? $clog2(MINUTE_DEPTH) : 1;
    localparam int MCW = $clog2(MINUTE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRUNE,
        S_HOLD
    } t_state;

    t_state r_state;

    logic [SEC_LIM_W-1:0] r_sec_lim;
    logic [MIN_LIM_W-1:0] r_min_lim;

    logic [SIW-1:0] r_sec_head, n_sec_head;
    logic [SCW-1:0] r_sec_cnt,  n_sec_cnt;
    logic [MIW-1:0] r_min_head, n_min_head;
    logic [MCW-1:0] r_min_cnt,  n_min_cnt;

    logic [31:0] r_now;
    logic [31:0] r_sec_rd;
    logic [31:0] r_min_rd;
    t_rsp        r_res;
    logic        r_out_valid;
    t_rsp        r_out_data;

    // log RAMs
    logic [31:0] sec_mem [SECOND_DEPTH];
    logic [31:0] min_mem [MINUTE_DEPTH];

    logic           sec_we, min_we;
    logic [SIW-1:0] sec_waddr;
    logic [MIW-1:0] min_waddr;
    logic [SCW:0]   sec_sum;
    logic [MCW:0]   min_sum;

    logic [31:0] sec_age, min_age;
    logic        sec_exp, min_exp, settle;
    logic        sec_full, min_full, sec_ok, min_ok, grant;
    logic [15:0] sec_wait, min_wait, wait_max, wait_ms;
    logic [SIW-1:0] sec_head_inc;
    logic [MIW-1:0] min_head_inc;
    logic        out_free;
    logic        rsp_load;
    t_rsp        res;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !r_out_valid || !i_out_stall;
    // a response word moves into the output register this cycle
    assign rsp_load    = out_free &&
                         (((r_state == S_PRUNE) && settle) || (r_state == S_HOLD));

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_lim <= '0;
            r_min_lim <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PER_SECOND: r_sec_lim <= i_cfg_wdata[SEC_LIM_W-1:0];
                CFG_PER_MINUTE: r_min_lim <= i_cfg_wdata[MIN_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // age of the oldest entry in each log, expiry and room checks
    always_comb begin
        sec_age  = r_now - r_sec_rd;
        min_age  = r_now - r_min_rd;
        sec_exp  = (r_sec_cnt != '0) && (sec_age >= SEC_SPAN_MS);
        min_exp  = (r_min_cnt != '0) && (min_age >= MIN_SPAN_MS);
        settle   = !sec_exp && !min_exp;

        sec_full = (r_sec_cnt == SCW'(SECOND_DEPTH));
        min_full = (r_min_cnt == MCW'(MINUTE_DEPTH));
        sec_ok   = (r_sec_lim == '0) ||
                   ((32'(r_sec_cnt) < 32'(r_sec_lim)) && !sec_full);
        min_ok   = (r_min_lim == '0) ||
                   ((32'(r_min_cnt) < 32'(r_min_lim)) && !min_full);
        grant    = sec_ok && min_ok;

        // retry hint: time until the oldest blocking entry ages out
        sec_wait = (!sec_ok && (r_sec_cnt != '0) && (sec_age < SEC_SPAN_MS)) ?
                   16'(SEC_SPAN_MS - sec_age) : 16'd0;
        min_wait = (!min_ok && (r_min_cnt != '0) && (min_age < MIN_SPAN_MS)) ?
                   16'(MIN_SPAN_MS - min_age) : 16'd0;
        wait_max = (sec_wait > min_wait) ? sec_wait : min_wait;
        wait_ms  = (wait_max < MIN_WAIT_MS) ? MIN_WAIT_MS : wait_max;

        res.granted = grant;
        res.stopped = 1'b0;
        res.wait_ms = grant ? 16'd0 : wait_ms;
    end

    // head/count update: retire during prune, append on grant
    always_comb begin
        sec_head_inc = (r_sec_head == SIW'(SECOND_DEPTH - 1)) ? '0 : r_sec_head + 1'b1;
        min_head_inc = (r_min_head == MIW'(MINUTE_DEPTH - 1)) ? '0 : r_min_head + 1'b1;

        sec_sum = (SCW+1)'(r_sec_head) + (SCW+1)'(r_sec_cnt);
        if (sec_sum >= (SCW+1)'(SECOND_DEPTH)) sec_sum = sec_sum - (SCW+1)'(SECOND_DEPTH);
        min_sum = (MCW+1)'(r_min_head) + (MCW+1)'(r_min_cnt);
        if (min_sum >= (MCW+1)'(MINUTE_DEPTH)) min_sum = min_sum - (MCW+1)'(MINUTE_DEPTH);

        n_sec_head = r_sec_head;
        n_sec_cnt  = r_sec_cnt;
        n_min_head = r_min_head;
        n_min_cnt  = r_min_cnt;
        sec_we     = 1'b0;
        min_we     = 1'b0;
        sec_waddr  = SIW'(sec_sum);
        min_waddr  = MIW'(min_sum);

        if (r_state == S_PRUNE) begin
            if (sec_exp) begin
                n_sec_head = sec_head_inc;
                n_sec_cnt  = r_sec_cnt - 1'b1;
            end
            if (min_exp) begin
                n_min_head = min_head_inc;
                n_min_cnt  = r_min_cnt - 1'b1;
            end
            if (settle && grant) begin
                // second log always records; full log overwrites its oldest
                sec_we = 1'b1;
                if (sec_full) begin
                    sec_waddr  = r_sec_head;
                    n_sec_head = sec_head_inc;
                end else begin
                    n_sec_cnt = r_sec_cnt + 1'b1;
                end
                // minute log records only while its limit is enabled
                if (r_min_lim != '0) begin
                    min_we = 1'b1;
                    if (min_full) begin
                        min_waddr  = r_min_head;
                        n_min_head = min_head_inc;
                    end else begin
                        n_min_cnt = r_min_cnt + 1'b1;
                    end
                end
            end
        end
    end

    // log RAMs: one write, one registered read at the next head
    always_ff @(posedge i_clk) begin
        if (sec_we) sec_mem[sec_waddr] <= r_now;
        r_sec_rd <= sec_mem[n_sec_head];
    end

    always_ff @(posedge i_clk) begin
        if (min_we) min_mem[min_waddr] <= r_now;
        r_min_rd <= min_mem[n_min_head];
    end

    // sequencer, log pointers and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sec_head  <= '0;
            r_sec_cnt   <= '0;
            r_min_head  <= '0;
            r_min_cnt   <= '0;
        end else begin
            r_sec_head <= n_sec_head;
            r_sec_cnt  <= n_sec_cnt;
            r_min_head <= n_min_head;
            r_min_cnt  <= n_min_cnt;
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_now <= i_in_data.now_ms;
                        if (i_in_data.stop) begin
                            r_res.granted <= 1'b0;
                            r_res.stopped <= 1'b1;
                            r_res.wait_ms <= 16'd0;
                            r_state       <= S_HOLD;
                        end else begin
                            r_state <= S_PRUNE;
                        end
                    end
                end
                S_PRUNE: begin
                    if (settle) begin
                        if (out_free) begin
                            r_out_data  <= res;
                            r_state     <= S_IDLE;
                        end else begin
                            r_res   <= res;
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // logs never hold more than their depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_sec_cnt) <= SECOND_DEPTH) && (32'(r_min_cnt) <= MINUTE_DEPTH))
        else $error("log count beyond depth");

    // a response is never both granted and stopped, and carries no hint then
    a_rsp_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.granted || o_out_data.stopped) |->
        !(o_out_data.granted && o_out_data.stopped) && (o_out_data.wait_ms == 16'd0))
        else $error("bad granted/stopped response");

    // denied responses carry a hint within the bounds
    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.granted && !o_out_data.stopped |->
        (o_out_data.wait_ms >= MIN_WAIT_MS) && (o_out_data.wait_ms <= MAX_WAIT_MS))
        else $error("retry hint out of range");

    // a grant grows or keeps the second log, never shrinks it past retirement
    a_grant_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRUNE) && settle && grant |=> (r_sec_cnt != '0))
        else $error("grant not recorded in second log");
`endif

endmodule

>>> verif/tb_dual_sliding_window_rate_limiter.sv
// Self-checking testbench for dual_sliding_window_rate_limiter: directed and random
// request words, per-word response prediction against a scoreboard, random stalls.
// Depends on dswrl_pkg and the design top level.
`timescale 1ns / 1ps

// Predicts the response word of each accepted request and checks arriving responses
class rate_limit_scoreboard;
    logic [31:0] sec_log [dswrl_pkg::SECOND_DEPTH_DEF];
    logic [31:0] min_log [dswrl_pkg::MINUTE_DEPTH_DEF];
    int sec_head, sec_count, min_head, min_count;
    int sec_limit, min_limit;
    dswrl_pkg::t_rsp pending [$];
    int errors;

    function new();
        sec_head = 0;
        sec_count = 0;
        min_head = 0;
        min_count = 0;
        sec_limit = 0;
        min_limit = 0;
        errors = 0;
    endfunction

    function void set_limit(logic [dswrl_pkg::CFG_IDX_W-1:0] idx,
                            logic [dswrl_pkg::CFG_W-1:0] value);
        if (idx == dswrl_pkg::CFG_PER_SECOND) begin
            sec_limit = int'(value[dswrl_pkg::SEC_LIM_W-1:0]);
        end else begin
            min_limit = int'(value);
        end
    endfunction

    // Admission decision for one request word
    function void note_request(dswrl_pkg::t_req w);
        dswrl_pkg::t_rsp exp_rsp;
        logic [31:0] age;
        logic [31:0] hint;
        bit sec_room;
        bit min_room;
        exp_rsp = '0;
        hint = 32'd0;
        if (w.stop) begin
            // stop: refused, no retire, no state change
            exp_rsp.stopped = 1'b1;
        end else begin
            // retire aged grants; age is modulo 2^32
            while (sec_count > 0 && w.now_ms - sec_log[sec_head] >= dswrl_pkg::SEC_SPAN_MS) begin
                sec_head = (sec_head + 1) % dswrl_pkg::SECOND_DEPTH_DEF;
                sec_count--;
            end
            while (min_count > 0 && w.now_ms - min_log[min_head] >= dswrl_pkg::MIN_SPAN_MS) begin
                min_head = (min_head + 1) % dswrl_pkg::MINUTE_DEPTH_DEF;
                min_count--;
            end
            // a limit above the log depth behaves as the depth
            sec_room = (sec_limit == 0) ||
                       (sec_count < sec_limit && sec_count < dswrl_pkg::SECOND_DEPTH_DEF);
            min_room = (min_limit == 0) ||
                       (min_count < min_limit && min_count < dswrl_pkg::MINUTE_DEPTH_DEF);
            if (sec_room && min_room) begin
                // second log always records; full and unlimited drops the oldest
                if (sec_count >= dswrl_pkg::SECOND_DEPTH_DEF) begin
                    sec_head = (sec_head + 1) % dswrl_pkg::SECOND_DEPTH_DEF;
                    sec_count = dswrl_pkg::SECOND_DEPTH_DEF - 1;
                end
                sec_log[(sec_head + sec_count) % dswrl_pkg::SECOND_DEPTH_DEF] = w.now_ms;
                sec_count++;
                // minute log records only while its limit is set; room check keeps it in depth
                if (min_limit != 0) begin
                    min_log[(min_head + min_count) % dswrl_pkg::MINUTE_DEPTH_DEF] = w.now_ms;
                    min_count++;
                end
                exp_rsp.granted = 1'b1;
            end else begin
                // retry hint: longest wait among the blocking windows, floored
                if (!sec_room && sec_count > 0) begin
                    age = w.now_ms - sec_log[sec_head];
                    if (age < dswrl_pkg::SEC_SPAN_MS && dswrl_pkg::SEC_SPAN_MS - age > hint)
                        hint = dswrl_pkg::SEC_SPAN_MS - age;
                end
                if (!min_room && min_count > 0) begin
                    age = w.now_ms - min_log[min_head];
                    if (age < dswrl_pkg::MIN_SPAN_MS && dswrl_pkg::MIN_SPAN_MS - age > hint)
                        hint = dswrl_pkg::MIN_SPAN_MS - age;
                end
                if (hint < dswrl_pkg::MIN_WAIT_MS)
                    hint = dswrl_pkg::MIN_WAIT_MS;
                exp_rsp.wait_ms = hint[15:0];
            end
        end
        pending.insert(pending.size(), exp_rsp);
    endfunction

    function void check_response(dswrl_pkg::t_rsp got);
        dswrl_pkg::t_rsp want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected response word: granted=%0b stopped=%0b wait_ms=%0d",
                         got.granted, got.stopped, got.wait_ms);
            return;
        end
        want = pending[0];
        pending.delete(0);
        if (got.granted !== want.granted || got.stopped !== want.stopped ||
            got.wait_ms !== want.wait_ms) begin
            errors++;
            if (errors <= 10)
                $display("response mismatch: exp granted=%0b stopped=%0b wait_ms=%0d, %s%0b %s%0b %s%0d",
                         want.granted, want.stopped, want.wait_ms,
                         "got granted=", got.granted, "stopped=", got.stopped,
                         "wait_ms=", got.wait_ms);
        end
    endfunction

    function void close_out();
        if (pending.size() != 0) begin
            errors++;
            $display("%0d expected response words never arrived", pending.size());
        end
    endfunction
endclass

module tb_dual_sliding_window_rate_limiter;
    import dswrl_pkg::*;

    localparam int STUCK_LIMIT     = 4000;
    localparam int HOLD_OFF_AT     = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RAND_PHASES     = 9;
    localparam int WORDS_PER_PHASE = 61;

    // limit settings per random phase; dense phases pack many requests per second
    localparam int SEC_PLAN [RAND_PHASES] = '{1, 0, 5, 64, 127, 3, 0, 10, 0};
    localparam int MIN_PLAN [RAND_PHASES] = '{1, 0, 40, 200, 2047, 0, 12, 1024, 0};
    localparam bit DENSE_PLAN [RAND_PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0, 0};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_data;

    rate_limit_scoreboard sb;
    bit quiet_tx;
    bit quiet_rx;
    bit held_off;
    int taken;
    int stuck_cycles;
    logic [31:0] stamp_ms;

    dual_sliding_window_rate_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_cycles(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic t_req req_word(logic [31:0] ms, logic stop_bit);
        t_req w;
        w.now_ms = ms;
        w.stop = stop_bit;
        return w;
    endfunction

    // Next request time: mostly forward, sometimes window-sized jumps, backwards or wrapping
    function automatic logic [31:0] next_stamp(bit dense);
        int pick;
        pick = $urandom_range(0, 99);
        if (dense && pick < 70)
            stamp_ms += $urandom_range(0, 12);
        else if (pick < 50)
            stamp_ms += $urandom_range(0, 40);
        else if (pick < 75)
            stamp_ms += $urandom_range(0, 1500);
        else if (pick < 85)
            stamp_ms += $urandom_range(900, 1100);
        else if (pick < 92)
            stamp_ms += $urandom_range(59000, 61000);
        else if (pick < 95)
            stamp_ms -= $urandom_range(1, 5000);
        else if (pick < 98)
            stamp_ms = $urandom();
        else
            stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        return stamp_ms;
    endfunction

    // Offer one request word after a random gap; returns in the step it is accepted
    task automatic send_word(input t_req w);
        int gap;
        gap = idle_cycles(quiet_tx);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(w);
    endtask

    // Both limit registers; unused upper bits of the second-limit word are random
    task automatic write_limits(input int sec_lim, input int min_lim);
        logic [CFG_W-1:0] sec_data;
        logic [CFG_W-1:0] min_data;
        sec_data = {4'($urandom_range(0, 15)), 7'(sec_lim)};
        min_data = 11'(min_lim);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_PER_SECOND;
        i_cfg_wdata <= sec_data;
        @(posedge i_clk);
        i_cfg_idx <= CFG_PER_MINUTE;
        i_cfg_wdata <= min_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(CFG_PER_SECOND, sec_data);
        sb.set_limit(CFG_PER_MINUTE, min_data);
    endtask

    // Drop valid, wait for every response, then let the block go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Response side: random stall per word, one long hold-off to back up the input
    initial begin
        int gap;
        held_off = 1'b0;
        taken = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = idle_cycles(quiet_rx);
            if (!held_off && taken == HOLD_OFF_AT) begin
                gap = HOLD_OFF_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_response(o_out_data);
            taken++;
        end
    end

    // Watchdog on cycles without any accepted request or taken response
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_dual_sliding_window_rate_limiter: done, errors");
            $finish;
        end
    end

    initial begin
        sb = new();
        stuck_cycles = 0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        stamp_ms = 32'd200000;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_PER_SECOND;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_stall <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: everything unlimited, stop with an all-ones time
        send_word(req_word(32'd0, 1'b0));
        send_word(req_word(32'hFFFF_FFFF, 1'b1));
        send_word(req_word(32'd5, 1'b0));
        settle();

        // tight limits: second-window deny, minute-window deny,
        // time moving backwards and wrapping past zero
        write_limits(2, 3);
        send_word(req_word(32'd100, 1'b0));
        send_word(req_word(32'd1000, 1'b0));
        send_word(req_word(32'd1001, 1'b0));
        send_word(req_word(32'd1005, 1'b0));
        send_word(req_word(32'd2100, 1'b0));
        send_word(req_word(32'd3200, 1'b0));
        send_word(req_word(32'd61000, 1'b0));
        send_word(req_word(32'hFFFF_FFFF, 1'b1));
        send_word(req_word(32'd500, 1'b0));
        send_word(req_word(32'hFFFF_FF00, 1'b0));
        send_word(req_word(32'd10, 1'b0));
        settle();

        // one grant per minute: largest hint
        write_limits(0, 1);
        send_word(req_word(32'd70000, 1'b0));
        send_word(req_word(32'd70000, 1'b0));
        send_word(req_word(32'd70999, 1'b0));
        send_word(req_word(32'd130000, 1'b0));
        settle();

        // random phases over the limit plan
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_limits(SEC_PLAN[p], MIN_PLAN[p]);
            quiet_tx = ($urandom_range(0, 2) == 0);
            quiet_rx = ($urandom_range(0, 2) == 0);
            repeat (WORDS_PER_PHASE)
                send_word(req_word(next_stamp(DENSE_PLAN[p]), $urandom_range(0, 11) == 0));
            settle();
        end

        repeat (20) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("tb_dual_sliding_window_rate_limiter: done, clean");
        else
            $display("tb_dual_sliding_window_rate_limiter: done, errors");
        $finish;
    end
endmodule

>>> dual_sliding_window_rate_limiter.f
design/dswrl_pkg.sv
design/dual_sliding_window_rate_limiter.sv
verif/tb_dual_sliding_window_rate_limiter.sv
